FILE: rtl/core/dqc_pkg.sv
package dqc_pkg;

   // Fixed field widths
   localparam int OUT_BITS           = 32;
   localparam int STAMP_BITS         = 32;
   localparam int INTERVAL_BITS      = 16;
   localparam int CSR_INDEX_BITS     = 2;
   localparam int CSR_DATA_BITS      = INTERVAL_BITS;
   localparam int COUNT_BITS_DEFAULT = 32;

   // Command codes
   localparam logic CMD_SAMPLE = 1'b0;
   localparam logic CMD_CLEAR  = 1'b1;

   // Register indexes
   localparam logic [CSR_INDEX_BITS-1:0] CSR_LEFT_NEGATE       = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_RIGHT_NEGATE      = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SNAPSHOT_INTERVAL = 2'd2;

   // Register reset values
   localparam logic                     LEFT_NEGATE_RESET  = 1'b1;
   localparam logic                     RIGHT_NEGATE_RESET = 1'b0;
   localparam logic [INTERVAL_BITS-1:0] INTERVAL_RESET     = 16'd50;

   // Per-word control from the input handshake to the lanes and the sampler
   typedef struct packed {
      logic sample;  // sampling word accepted
      logic clear;   // clear word accepted
   } word_ctrl_type;

endpackage

FILE: rtl/core/dqc_lane.sv
module dqc_lane
   import dqc_pkg::*;
#(
   parameter int COUNT_BITS = COUNT_BITS_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  word_ctrl_type       ctrl,
   input  logic                chan_a,
   input  logic                chan_b,
   input  logic                negate,
   output logic [OUT_BITS-1:0] total
);

   logic [COUNT_BITS-1:0] pos_ff, pos_in;
   logic                  a_prev_ff, a_prev_in;
   logic                  step_up;

   assign step_up = (chan_b != chan_a) ^ negate;

   always_comb begin
      pos_in    = pos_ff;
      a_prev_in = a_prev_ff;
      if (ctrl.clear) begin
         pos_in = '0;
      end else if (ctrl.sample && (chan_a != a_prev_ff)) begin
         pos_in    = step_up ? pos_ff + COUNT_BITS'(1) : pos_ff - COUNT_BITS'(1);
         a_prev_in = chan_a;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff    <= '0;
         a_prev_ff <= 1'b1;
      end else begin
         pos_ff    <= pos_in;
         a_prev_ff <= a_prev_in;
      end
   end

   // Updated count, sign-extended or truncated to the output width
   generate
      if (COUNT_BITS >= OUT_BITS) begin : g_trunc
         assign total = pos_in[OUT_BITS-1:0];
      end else begin : g_sext
         assign total = {{(OUT_BITS-COUNT_BITS){pos_in[COUNT_BITS-1]}}, pos_in};
      end
   endgenerate

endmodule

FILE: rtl/core/dqc_snap.sv
module dqc_snap
   import dqc_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  word_ctrl_type            ctrl,
   input  logic                     ms_tick,
   input  logic [INTERVAL_BITS-1:0] interval,
   input  logic [OUT_BITS-1:0]      left_total,
   input  logic [OUT_BITS-1:0]      right_total,
   output logic                     out_full,
   input  logic                     rsp_stall,
   output logic                     rsp_valid,
   output logic signed [OUT_BITS-1:0] rsp_left_total,
   output logic signed [OUT_BITS-1:0] rsp_right_total,
   output logic [STAMP_BITS-1:0]    rsp_stamp_ms
);

   logic [STAMP_BITS-1:0] now_ff, now_in;
   logic [STAMP_BITS-1:0] last_ff, last_in;
   logic                  armed_ff, armed_in;
   logic [STAMP_BITS-1:0] elapsed;
   logic                  fire;

   logic                  valid_ff, valid_in;
   logic [OUT_BITS-1:0]   left_ff, left_in;
   logic [OUT_BITS-1:0]   right_ff, right_in;
   logic [STAMP_BITS-1:0] stamp_ff, stamp_in;

   assign now_in  = (ctrl.sample && ms_tick) ? now_ff + STAMP_BITS'(1) : now_ff;
   assign elapsed = now_in - last_ff;
   assign fire    = ctrl.sample && armed_ff && (elapsed >= STAMP_BITS'(interval));

   always_comb begin
      armed_in = armed_ff;
      last_in  = last_ff;
      if (ctrl.sample && !armed_ff) begin
         armed_in = 1'b1;
         last_in  = now_in;
      end else if (fire) begin
         last_in = now_in;
      end
   end

   // Output word register; upstream is held only while it is full and stalled
   assign out_full = valid_ff && rsp_stall;

   always_comb begin
      valid_in = valid_ff && rsp_stall;
      left_in  = left_ff;
      right_in = right_ff;
      stamp_in = stamp_ff;
      if (fire) begin
         valid_in = 1'b1;
         left_in  = left_total;
         right_in = right_total;
         stamp_in = now_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         now_ff   <= '0;
         last_ff  <= '0;
         armed_ff <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         now_ff   <= now_in;
         last_ff  <= last_in;
         armed_ff <= armed_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      left_ff  <= left_in;
      right_ff <= right_in;
      stamp_ff <= stamp_in;
   end

   assign rsp_valid       = valid_ff;
   assign rsp_left_total  = left_ff;
   assign rsp_right_total = right_ff;
   assign rsp_stamp_ms    = stamp_ff;

endmodule

FILE: rtl/core/dual_quadrature_counter_snapshot_core.sv
// Dual quadrature encoder counter with periodic snapshots (x2 decoding).
//
// Input channel (req_*): one word per clock carries a command, the A/B pin
// levels of both encoders and a millisecond tick. cmd sample decodes A edges
// into both position counters and advances time; cmd clear zeroes both counts.
// Result channel (rsp_*): a snapshot word (both counts, time stamp) is sent
// each time the elapsed time since the last snapshot reaches the interval.
// The first sampling word only arms the sampler.
// Config port (csr_*): direction signs and interval; write only while idle.
//
// Throughput: one word per cycle while req_stall is low. Each word is handled in
// the cycle it is accepted; its snapshot appears on rsp_* the next cycle.
// The two encoder lanes run in parallel; the sampler merges their counts into
// the single output register; req_stall is high only while that register is
// full and rsp_stall is high.
// If the receiver stalls while a snapshot is pending, req_stall rises and the
// pending word holds until taken.
// Reset: counts, time and sampler cleared, previous A levels set high,
// registers back to defaults; no clearing pass is needed.
module dual_quadrature_counter_snapshot_core
   import dqc_pkg::*;
#(
   parameter int COUNT_BITS = COUNT_BITS_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   // config write port
   input  logic                       csr_wr_en,
   input  logic [CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [CSR_DATA_BITS-1:0]   csr_wr_data,
   // input words
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic                       req_cmd,
   input  logic                       req_left_a,
   input  logic                       req_left_b,
   input  logic                       req_right_a,
   input  logic                       req_right_b,
   input  logic                       req_ms_tick,
   // snapshot words
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic signed [OUT_BITS-1:0] rsp_left_total,
   output logic signed [OUT_BITS-1:0] rsp_right_total,
   output logic [STAMP_BITS-1:0]      rsp_stamp_ms
);

   logic                     left_negate_ff, left_negate_in;
   logic                     right_negate_ff, right_negate_in;
   logic [INTERVAL_BITS-1:0] interval_ff, interval_in;

   logic                     accept;
   logic                     out_full;
   word_ctrl_type            ctrl;
   logic [OUT_BITS-1:0]      left_total;
   logic [OUT_BITS-1:0]      right_total;

   // Config registers
   always_comb begin
      left_negate_in  = left_negate_ff;
      right_negate_in = right_negate_ff;
      interval_in     = interval_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_LEFT_NEGATE:       left_negate_in  = csr_wr_data[0];
            CSR_RIGHT_NEGATE:      right_negate_in = csr_wr_data[0];
            CSR_SNAPSHOT_INTERVAL: interval_in     = csr_wr_data[INTERVAL_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         left_negate_ff  <= LEFT_NEGATE_RESET;
         right_negate_ff <= RIGHT_NEGATE_RESET;
         interval_ff     <= INTERVAL_RESET;
      end else begin
         left_negate_ff  <= left_negate_in;
         right_negate_ff <= right_negate_in;
         interval_ff     <= interval_in;
      end
   end

   // Handshake: hold upstream only while a snapshot waits on a stalled sink
   assign req_stall  = out_full;
   assign accept     = req_valid && !out_full;
   assign ctrl.sample = accept && (req_cmd == CMD_SAMPLE);
   assign ctrl.clear  = accept && (req_cmd == CMD_CLEAR);

   dqc_lane #(
      .COUNT_BITS (COUNT_BITS)
   ) u_left_lane (
      .clock  (clock),
      .reset  (reset),
      .ctrl   (ctrl),
      .chan_a (req_left_a),
      .chan_b (req_left_b),
      .negate (left_negate_ff),
      .total  (left_total)
   );

   dqc_lane #(
      .COUNT_BITS (COUNT_BITS)
   ) u_right_lane (
      .clock  (clock),
      .reset  (reset),
      .ctrl   (ctrl),
      .chan_a (req_right_a),
      .chan_b (req_right_b),
      .negate (right_negate_ff),
      .total  (right_total)
   );

   // Merge: time base, sampler and output register
   dqc_snap u_snap (
      .clock           (clock),
      .reset           (reset),
      .ctrl            (ctrl),
      .ms_tick         (req_ms_tick),
      .interval        (interval_ff),
      .left_total      (left_total),
      .right_total     (right_total),
      .out_full        (out_full),
      .rsp_stall       (rsp_stall),
      .rsp_valid       (rsp_valid),
      .rsp_left_total  (rsp_left_total),
      .rsp_right_total (rsp_right_total),
      .rsp_stamp_ms    (rsp_stamp_ms)
   );

endmodule

FILE: bench/dqc_snapshot_checker.sv
`timescale 1ns / 100ps

module dqc_snapshot_checker
   import dqc_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_wr_en,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_wr_data,
   input  logic                      req_valid,
   input  logic                      req_stall,
   input  logic                      req_cmd,
   input  logic                      req_left_a,
   input  logic                      req_left_b,
   input  logic                      req_right_a,
   input  logic                      req_right_b,
   input  logic                      req_ms_tick,
   input  logic                      rsp_valid,
   input  logic                      rsp_stall,
   input  logic signed [OUT_BITS-1:0] rsp_left_total,
   input  logic signed [OUT_BITS-1:0] rsp_right_total,
   input  logic [STAMP_BITS-1:0]     rsp_stamp_ms,
   output int                        mismatch_count,
   output int                        snapshots_owed
);

   typedef struct packed {
      logic signed [OUT_BITS-1:0] left_total;
      logic signed [OUT_BITS-1:0] right_total;
      logic [STAMP_BITS-1:0]      stamp_ms;
   } snapshot_type;

   snapshot_type snapshot_q[$];

   // shadow of the block's registers and state
   logic                     left_down;
   logic                     right_down;
   logic [INTERVAL_BITS-1:0] snap_period;
   logic [OUT_BITS-1:0]      left_pos;
   logic [OUT_BITS-1:0]      right_pos;
   logic                     left_a_seen;
   logic                     right_a_seen;
   logic [STAMP_BITS-1:0]    clock_ms;
   logic [STAMP_BITS-1:0]    last_stamp_ms;
   logic                     sampler_live;

   // x2 decode: count only on a change of A
   function automatic logic [OUT_BITS-1:0] decode_count(input logic [OUT_BITS-1:0] count,
                                                        input logic a_seen, input logic a,
                                                        input logic b, input logic down);
      if (a == a_seen)
         return count;
      return ((b != a) ^ down) ? count + OUT_BITS'(1) : count - OUT_BITS'(1);
   endfunction

   task automatic predict_snapshot(input logic cmd, input logic la, input logic lb,
                                   input logic ra, input logic rb, input logic tick);
      snapshot_type snap;
      begin
         if (cmd == CMD_CLEAR) begin
            left_pos  = '0;
            right_pos = '0;
         end else begin
            left_pos     = decode_count(left_pos, left_a_seen, la, lb, left_down);
            left_a_seen  = la;
            right_pos    = decode_count(right_pos, right_a_seen, ra, rb, right_down);
            right_a_seen = ra;
            if (tick)
               clock_ms = clock_ms + STAMP_BITS'(1);
            if (!sampler_live) begin
               sampler_live  = 1'b1;
               last_stamp_ms = clock_ms;
            end else if (clock_ms - last_stamp_ms >= {16'd0, snap_period}) begin
               snap.left_total  = left_pos;
               snap.right_total = right_pos;
               snap.stamp_ms    = clock_ms;
               snapshot_q.push_back(snap);
               last_stamp_ms = clock_ms;
            end
         end
      end
   endtask

   task automatic check_snapshot();
      snapshot_type want;
      begin
         if (snapshot_q.size() == 0) begin
            $display("%0t: snapshot with none expected: left %0d right %0d stamp %0d",
                     $time, rsp_left_total, rsp_right_total, rsp_stamp_ms);
            mismatch_count++;
         end else begin
            want = snapshot_q.pop_front();
            if (rsp_left_total !== want.left_total) begin
               $display("%0t: left_total expected %0d got %0d",
                        $time, want.left_total, rsp_left_total);
               mismatch_count++;
            end
            if (rsp_right_total !== want.right_total) begin
               $display("%0t: right_total expected %0d got %0d",
                        $time, want.right_total, rsp_right_total);
               mismatch_count++;
            end
            if (rsp_stamp_ms !== want.stamp_ms) begin
               $display("%0t: stamp_ms expected %0d got %0d",
                        $time, want.stamp_ms, rsp_stamp_ms);
               mismatch_count++;
            end
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         left_down     = LEFT_NEGATE_RESET;
         right_down    = RIGHT_NEGATE_RESET;
         snap_period   = INTERVAL_RESET;
         left_pos      = '0;
         right_pos     = '0;
         left_a_seen   = 1'b1;
         right_a_seen  = 1'b1;
         clock_ms      = '0;
         last_stamp_ms = '0;
         sampler_live  = 1'b0;
         snapshot_q.delete();
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               CSR_LEFT_NEGATE:       left_down   = csr_wr_data[0];
               CSR_RIGHT_NEGATE:      right_down  = csr_wr_data[0];
               CSR_SNAPSHOT_INTERVAL: snap_period = csr_wr_data[INTERVAL_BITS-1:0];
               default: ;
            endcase
         end
         if (req_valid && !req_stall)
            predict_snapshot(req_cmd, req_left_a, req_left_b, req_right_a, req_right_b,
                             req_ms_tick);
         if (rsp_valid && !rsp_stall)
            check_snapshot();
      end
      snapshots_owed = snapshot_q.size();
   end

endmodule

FILE: bench/dual_quadrature_counter_snapshot_core_tb.sv
`timescale 1ns / 100ps

module dual_quadrature_counter_snapshot_core_tb;
   import dqc_pkg::*;

   localparam int HALF_PERIOD    = 6;
   localparam int RESET_CYCLES   = 11;
   localparam int QUIET_LIMIT    = 3000;  // well above the long receiver hold-off
   localparam int HOLD_CYCLES    = 400;   // receiver hold-off to back up the input side
   localparam int SETTLE_CYCLES  = 3;     // margin after the last snapshot, before a register write
   localparam int DRAIN_CYCLES   = 10;
   localparam int CLEAR_PCT      = 3;

   logic                       clock;
   logic                       reset        = 1'b1;
   logic                       csr_wr_en    = 1'b0;
   logic [CSR_INDEX_BITS-1:0]  csr_index    = '0;
   logic [CSR_DATA_BITS-1:0]   csr_wr_data  = '0;
   logic                       req_valid    = 1'b0;
   logic                       req_stall;
   logic                       req_cmd      = CMD_SAMPLE;
   logic                       req_left_a   = 1'b1;
   logic                       req_left_b   = 1'b1;
   logic                       req_right_a  = 1'b1;
   logic                       req_right_b  = 1'b1;
   logic                       req_ms_tick  = 1'b0;
   logic                       rsp_valid;
   logic                       rsp_stall    = 1'b0;
   logic signed [OUT_BITS-1:0] rsp_left_total;
   logic signed [OUT_BITS-1:0] rsp_right_total;
   logic [STAMP_BITS-1:0]      rsp_stamp_ms;

   int mismatch_count;
   int snapshots_owed;

   // idle rates, in percent, set per phase by the stimulus
   int send_idle_pct = 0;
   int recv_idle_pct = 0;

   // one long receiver hold-off, requested by the stimulus, counted below
   bit hold_request = 1'b0;
   bit hold_done    = 1'b0;
   int hold_left    = 0;

   int quiet_cycles = 0;

   // quadrature walkers: phase 0..3 maps to Gray-coded A/B levels
   logic [1:0] left_phase  = 2'd2;
   logic [1:0] right_phase = 2'd2;
   logic       left_fwd    = 1'b1;
   logic       right_fwd   = 1'b0;

   dual_quadrature_counter_snapshot_core i_dut (
      .clock           (clock),
      .reset           (reset),
      .csr_wr_en       (csr_wr_en),
      .csr_index       (csr_index),
      .csr_wr_data     (csr_wr_data),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_cmd         (req_cmd),
      .req_left_a      (req_left_a),
      .req_left_b      (req_left_b),
      .req_right_a     (req_right_a),
      .req_right_b     (req_right_b),
      .req_ms_tick     (req_ms_tick),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_left_total  (rsp_left_total),
      .rsp_right_total (rsp_right_total),
      .rsp_stamp_ms    (rsp_stamp_ms)
   );

   dqc_snapshot_checker i_checker (
      .clock           (clock),
      .reset           (reset),
      .csr_wr_en       (csr_wr_en),
      .csr_index       (csr_index),
      .csr_wr_data     (csr_wr_data),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_cmd         (req_cmd),
      .req_left_a      (req_left_a),
      .req_left_b      (req_left_b),
      .req_right_a     (req_right_a),
      .req_right_b     (req_right_b),
      .req_ms_tick     (req_ms_tick),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_left_total  (rsp_left_total),
      .rsp_right_total (rsp_right_total),
      .rsp_stamp_ms    (rsp_stamp_ms),
      .mismatch_count  (mismatch_count),
      .snapshots_owed  (snapshots_owed)
   );

   initial begin
      clock = 1'b0;
      forever #HALF_PERIOD clock = ~clock;
   end

   // Receiver: random stall at the current rate, except during the one
   // long hold-off, which lets the snapshot register fill and back up req.
   always @(negedge clock) begin
      if (hold_request && !hold_done) begin
         hold_done = 1'b1;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
   end

   // Watchdog: any accepted word, register write or reset counts as progress.
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_wr_en || reset) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("dual_quadrature_counter_snapshot_core_tb: done, errors");
            $finish;
         end
      end
   end

   // Entered and left at a falling edge. Valid stays up between words unless
   // the sender chooses to idle; a stalled word holds its payload.
   task automatic send_word(input logic cmd, input logic la, input logic lb,
                            input logic ra, input logic rb, input logic tick);
      begin
         while ($urandom_range(99) < send_idle_pct) begin
            req_valid <= 1'b0;
            @(negedge clock);
         end
         req_valid   <= 1'b1;
         req_cmd     <= cmd;
         req_left_a  <= la;
         req_left_b  <= lb;
         req_right_a <= ra;
         req_right_b <= rb;
         req_ms_tick <= tick;
         @(posedge clock);
         while (req_stall)
            @(posedge clock);
         @(negedge clock);
      end
   endtask

   // Mostly clean quadrature motion with direction reversals; a few words
   // carry random levels, which break the Gray sequence on purpose.
   task automatic walk_encoder(inout logic [1:0] phase, inout logic fwd,
                               output logic a, output logic b);
      int roll;
      begin
         roll = $urandom_range(99);
         if (roll < 5)
            fwd = ~fwd;
         if (roll < 10) begin
            a = 1'($urandom_range(1));
            b = 1'($urandom_range(1));
         end else begin
            if (roll < 65)
               phase = fwd ? phase + 2'd1 : phase - 2'd1;
            a = phase[0] ^ phase[1];
            b = phase[1];
         end
      end
   endtask

   task automatic random_word(input int tick_pct);
      logic cmd;
      logic la, lb, ra, rb;
      begin
         cmd = ($urandom_range(99) < CLEAR_PCT) ? CMD_CLEAR : CMD_SAMPLE;
         walk_encoder(left_phase, left_fwd, la, lb);
         walk_encoder(right_phase, right_fwd, ra, rb);
         send_word(cmd, la, lb, ra, rb, $urandom_range(99) < tick_pct);
      end
   endtask

   // Registers change only with nothing in flight.
   task automatic wait_idle();
      begin
         req_valid <= 1'b0;
         while (snapshots_owed != 0)
            @(negedge clock);
         repeat (SETTLE_CYCLES) @(negedge clock);
      end
   endtask

   task automatic csr_write(input logic [CSR_INDEX_BITS-1:0] idx,
                            input logic [CSR_DATA_BITS-1:0] data);
      begin
         csr_wr_en   <= 1'b1;
         csr_index   <= idx;
         csr_wr_data <= data;
         @(negedge clock);
      end
   endtask

   task automatic run_phase(input logic left_neg, input logic right_neg,
                            input logic [INTERVAL_BITS-1:0] interval, input int words,
                            input int tick_pct, input int send_pct, input int recv_pct,
                            input bit press);
      begin
         wait_idle();
         csr_write(CSR_LEFT_NEGATE, {15'd0, left_neg});
         csr_write(CSR_RIGHT_NEGATE, {15'd0, right_neg});
         csr_write(CSR_SNAPSHOT_INTERVAL, interval);
         csr_wr_en     <= 1'b0;
         send_idle_pct = send_pct;
         recv_idle_pct = recv_pct;
         if (press)
            hold_request = 1'b1;
         repeat (words) random_word(tick_pct);
      end
   endtask

   initial begin
      repeat (RESET_CYCLES) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed, register defaults (left counts down on forward motion).
      // First sampling word arms the sampler at time zero, no snapshot.
      send_word(CMD_SAMPLE, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0);
      // clear ignores pins and tick: no edges taken, time does not move
      send_word(CMD_CLEAR,  1'b0, 1'b0, 1'b0, 1'b0, 1'b1);
      // left A falls with B equal, right A falls with B different
      send_word(CMD_SAMPLE, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1);
      // left A rises with B different, right A rises with B equal
      send_word(CMD_SAMPLE, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0);
      // only B moves: no count
      send_word(CMD_SAMPLE, 1'b1, 1'b1, 1'b1, 1'b0, 1'b1);
      send_word(CMD_SAMPLE, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1);
      send_word(CMD_SAMPLE, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0);
      send_word(CMD_SAMPLE, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1);
      // clear between edges: previous A levels survive
      send_word(CMD_CLEAR,  1'b1, 1'b1, 1'b1, 1'b1, 1'b1);
      send_word(CMD_SAMPLE, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1);
      send_word(CMD_SAMPLE, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0);
      send_word(CMD_SAMPLE, 1'b0, 1'b0, 1'b1, 1'b1, 1'b1);
      // back to back counting up from zero on both lanes
      send_word(CMD_CLEAR,  1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
      send_word(CMD_SAMPLE, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1);
      send_word(CMD_SAMPLE, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1);
      send_word(CMD_SAMPLE, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1);

      // Random part. Sender 35 / receiver 49 percent idle first.
      run_phase(1'b0, 1'b1, 16'd1, 300, 50, 35, 49, 1'b0);
      // Zero interval: every armed sampling word snapshots. The long receiver
      // hold-off lands here so the output register fills and req stalls.
      run_phase(1'b1, 1'b1, 16'd0, 300, 50, 35, 49, 1'b1);
      // Idle rates swapped.
      run_phase(1'b0, 1'b0, 16'd3, 300, 60, 49, 35, 1'b0);
      // Largest interval: no snapshot is reachable, counting only.
      run_phase(1'b1, 1'b0, 16'hFFFF, 150, 70, 49, 35, 1'b0);
      // No idling on either side.
      run_phase(1'b0, 1'b1, 16'd2, 300, 50, 0, 0, 1'b0);
      run_phase(1'b1, 1'b1, 16'd7, 300, 90, 0, 0, 1'b0);
      run_phase(1'b0, 1'b0, 16'd50, 200, 100, 0, 0, 1'b0);

      req_valid <= 1'b0;
      while (snapshots_owed != 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);

      if (mismatch_count == 0 && snapshots_owed == 0)
         $display("dual_quadrature_counter_snapshot_core_tb: done, clean");
      else
         $display("dual_quadrature_counter_snapshot_core_tb: done, errors");
      $finish;
   end

endmodule
